### sv/ssgr_pkg.sv
package ssgr_pkg;

  // Glyph geometry
  localparam int SegLen   = 16;
  localparam int SegThick = 5;
  localparam int Gap      = 2;
  localparam int Advance  = 5 * Gap + SegLen;
  localparam int StripsPerSeg = 5;

  localparam int CoordW = 8;
  localparam int MaskW  = SegLen;
  localparam int DigitW = 4;
  localparam int DirW   = 2;
  localparam int SegIdxW   = 3;
  localparam int StripIdxW = 3;

  localparam logic [DigitW-1:0] MaxDigit = DigitW'(9);
  localparam logic [StripIdxW-1:0] LastStrip = StripIdxW'(StripsPerSeg - 1);

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [MaskW-1:0]  mask_t;
  typedef logic [DigitW-1:0] digit_t;
  typedef logic [DirW-1:0]   dir_t;
  typedef logic [SegIdxW-1:0]   seg_idx_t;
  typedef logic [StripIdxW-1:0] strip_idx_t;

  // Step direction codes
  localparam dir_t DirPosX = 2'd0;
  localparam dir_t DirPosY = 2'd1;
  localparam dir_t DirNegY = 2'd2;

  // Signed offsets as 8-bit two's complement
  localparam coord_t OffGap   = CoordW'(Gap);
  localparam coord_t OffNGap  = CoordW'(-Gap);
  localparam coord_t OffTop   = CoordW'(2 * SegLen + 3 * Gap - SegThick);
  localparam coord_t OffUpper = CoordW'(SegLen + 2 * Gap);
  localparam coord_t OffSide  = CoordW'(SegLen + 2 * Gap - SegThick);
  localparam coord_t OffNSide = CoordW'(-(SegLen + 2 * Gap - SegThick));
  localparam coord_t OffMid   = CoordW'(SegLen - SegThick + 2 * Gap + 1);
  localparam coord_t OffZero  = '0;
  localparam coord_t OffAdv   = CoordW'(Advance);
  localparam coord_t OffNAdv  = CoordW'(-Advance);

  typedef enum logic [2:0] {
    KindTop, KindLeft, KindBottom, KindRight, KindMiddle
  } kind_e;

  typedef enum logic {
    StIdle, StRun
  } state_e;

  typedef struct packed {
    coord_t dx;
    coord_t dy;
  } offset_t;

  typedef struct packed {
    coord_t strip_x;
    coord_t strip_y;
    dir_t   strip_dir;
    mask_t  pixel_mask;
    logic   bad_digit;
    logic   last_strip;
  } strip_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic slot_free;
    logic last;
  } dp_stat_t;

  // Number of lit segments per digit
  function automatic seg_idx_t digit_count(digit_t d);
    seg_idx_t n;
    unique case (d)
      4'd0: n = 3'd6;
      4'd1: n = 3'd2;
      4'd2: n = 3'd5;
      4'd3: n = 3'd5;
      4'd4: n = 3'd4;
      4'd5: n = 3'd5;
      4'd6: n = 3'd6;
      4'd7: n = 3'd3;
      4'd8: n = 3'd7;
      4'd9: n = 3'd6;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  // Segment emitted at position i of a digit's sequence
  function automatic seg_idx_t digit_seg(digit_t d, seg_idx_t i);
    logic [20:0] row;
    unique case (d)
      4'd0: row = {3'd0, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
      4'd1: row = {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd5};
      4'd2: row = {3'd0, 3'd0, 3'd3, 3'd2, 3'd6, 3'd5, 3'd0};
      4'd3: row = {3'd0, 3'd0, 3'd6, 3'd5, 3'd4, 3'd3, 3'd0};
      4'd4: row = {3'd0, 3'd0, 3'd0, 3'd6, 3'd5, 3'd4, 3'd1};
      4'd5: row = {3'd0, 3'd0, 3'd6, 3'd4, 3'd3, 3'd1, 3'd0};
      4'd6: row = {3'd0, 3'd6, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
      4'd7: row = {3'd0, 3'd0, 3'd0, 3'd0, 3'd5, 3'd4, 3'd0};
      4'd8: row = {3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
      4'd9: row = {3'd0, 3'd6, 3'd5, 3'd4, 3'd3, 3'd1, 3'd0};
      default: row = '0;
    endcase
    unique case (i)
      3'd0: return row[2:0];
      3'd1: return row[5:3];
      3'd2: return row[8:6];
      3'd3: return row[11:9];
      3'd4: return row[14:12];
      3'd5: return row[17:15];
      3'd6: return row[20:18];
      default: return 3'd0;
    endcase
  endfunction

  function automatic kind_e seg_kind(seg_idx_t seg);
    kind_e k;
    unique case (seg)
      3'd0: k = KindTop;
      3'd1, 3'd2: k = KindLeft;
      3'd3: k = KindBottom;
      3'd4, 3'd5: k = KindRight;
      3'd6: k = KindMiddle;
      default: k = KindTop;
    endcase
    return k;
  endfunction

  // Start offset of a segment from the glyph origin
  function automatic offset_t seg_offset(seg_idx_t seg, logic land);
    offset_t o;
    unique case (seg)
      3'd0: o = land ? '{OffTop, OffNGap}     : '{OffGap, OffTop};
      3'd1: o = land ? '{OffUpper, OffZero}   : '{OffZero, OffUpper};
      3'd2: o = land ? '{OffGap, OffZero}     : '{OffZero, OffGap};
      3'd3: o = land ? '{OffZero, OffNGap}    : '{OffGap, OffZero};
      3'd4: o = land ? '{OffGap, OffNSide}    : '{OffSide, OffGap};
      3'd5: o = land ? '{OffUpper, OffNSide}  : '{OffSide, OffUpper};
      3'd6: o = land ? '{OffMid, OffNGap}     : '{OffGap, OffMid};
      default: o = '{OffZero, OffZero};
    endcase
    return o;
  endfunction

  // Trapezoid bitmap rows
  function automatic mask_t kind_mask(kind_e k, strip_idx_t s);
    mask_t m;
    logic [5*MaskW-1:0] row;
    unique case (k)
      KindTop:    row = {16'hFFFF, 16'h7FFE, 16'h3FFC, 16'h1FF8, 16'h0FF0};
      KindLeft:   row = {16'h07F0, 16'h0FF8, 16'h1FFC, 16'h3FFE, 16'h7FFF};
      KindBottom: row = {16'h0FF0, 16'h1FF8, 16'h3FFC, 16'h7FFE, 16'hFFFF};
      KindRight:  row = {16'h7FFF, 16'h3FFE, 16'h1FFC, 16'h0FF8, 16'h07F0};
      KindMiddle: row = {16'h3FFC, 16'h7FFE, 16'hFFFF, 16'h7FFE, 16'h3FFC};
      default:    row = '0;
    endcase
    unique case (s)
      3'd0: m = row[15:0];
      3'd1: m = row[31:16];
      3'd2: m = row[47:32];
      3'd3: m = row[63:48];
      3'd4: m = row[79:64];
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

### sv/ssgr_in_if.sv
interface ssgr_in_if;
  import ssgr_pkg::*;

  logic   valid;
  logic   ready;
  logic   command;
  coord_t origin_x;
  coord_t origin_y;
  digit_t digit;

  modport source (output valid, command, origin_x, origin_y, digit, input ready);
  modport sink   (input valid, command, origin_x, origin_y, digit, output ready);
endinterface

### sv/ssgr_out_if.sv
interface ssgr_out_if;
  import ssgr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t strip_x;
  coord_t strip_y;
  dir_t   strip_dir;
  mask_t  pixel_mask;
  logic   bad_digit;
  logic   last_strip;

  modport source (output valid, strip_x, strip_y, strip_dir, pixel_mask, bad_digit,
                  last_strip, input ready);
  modport sink   (input valid, strip_x, strip_y, strip_dir, pixel_mask, bad_digit,
                  last_strip, output ready);
endinterface

### sv/ssgr_cfg_if.sv
interface ssgr_cfg_if;
  logic valid;
  logic ready;
  logic landscape_mode;

  modport source (output valid, landscape_mode, input ready);
  modport sink   (input valid, landscape_mode, output ready);
endinterface

### sv/ssgr_ctrl.sv
module ssgr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ssgr_pkg::dp_stat_t   stat_i,
  output ssgr_pkg::ctrl_cmd_t  cmd_o,
  output ssgr_pkg::state_e     state_o
);
  import ssgr_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign state_o = state_q;
endmodule

### sv/ssgr_datapath.sv
module ssgr_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ssgr_pkg::ctrl_cmd_t  cmd_i,
  output ssgr_pkg::dp_stat_t   stat_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_land_i,
  input  logic                 in_command_i,
  input  ssgr_pkg::coord_t     in_origin_x_i,
  input  ssgr_pkg::coord_t     in_origin_y_i,
  input  ssgr_pkg::digit_t     in_digit_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output ssgr_pkg::strip_t     out_strip_o
);
  import ssgr_pkg::*;

  logic       land_q;
  coord_t     pen_x_q, pen_y_q;
  coord_t     ox_q, oy_q;
  digit_t     dig_q;
  seg_idx_t   seg_idx_q;
  strip_idx_t strip_idx_q;
  logic       out_valid_q;
  strip_t     out_q;

  coord_t     ox_sel, oy_sel;
  logic       bad_in;
  logic       bad;
  logic       seg_last;
  seg_idx_t   seg;
  kind_e      kind;
  offset_t    off;
  coord_t     sx, sy, s_ext;
  strip_t     cur;

  // Origin select on load
  assign ox_sel = in_command_i ? pen_x_q : in_origin_x_i;
  assign oy_sel = in_command_i ? pen_y_q : in_origin_y_i;
  assign bad_in = in_digit_i > MaxDigit;

  // Current strip
  assign bad      = dig_q > MaxDigit;
  assign seg      = digit_seg(dig_q, seg_idx_q);
  assign kind     = seg_kind(seg);
  assign off      = seg_offset(seg, land_q);
  assign sx       = ox_q + off.dx;
  assign sy       = oy_q + off.dy;
  assign s_ext    = CoordW'(strip_idx_q);
  assign seg_last = seg_idx_q == digit_count(dig_q) - 3'd1;

  always_comb begin
    cur = '0;
    if (bad) begin
      cur.bad_digit  = 1'b1;
      cur.last_strip = 1'b1;
    end else begin
      cur.pixel_mask = kind_mask(kind, strip_idx_q);
      cur.last_strip = seg_last && (strip_idx_q == LastStrip);
      case (kind)
        KindTop, KindBottom, KindMiddle: begin
          if (land_q) begin
            cur.strip_x = sx + s_ext; cur.strip_y = sy; cur.strip_dir = DirNegY;
          end else begin
            cur.strip_x = sx; cur.strip_y = sy + s_ext; cur.strip_dir = DirPosX;
          end
        end
        default: begin
          if (land_q) begin
            cur.strip_x = sx; cur.strip_y = sy - s_ext; cur.strip_dir = DirPosX;
          end else begin
            cur.strip_x = sx + s_ext; cur.strip_y = sy; cur.strip_dir = DirPosY;
          end
        end
      endcase
    end
  end

  // Control state: mode, pen, counters, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      land_q      <= 1'b0;
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      seg_idx_q   <= '0;
      strip_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        land_q <= cfg_land_i;
      end
      if (cmd_i.load) begin
        seg_idx_q   <= '0;
        strip_idx_q <= '0;
        if (!bad_in) begin
          pen_x_q <= land_q ? ox_sel : ox_sel + OffAdv;
          pen_y_q <= land_q ? oy_sel + OffNAdv : oy_sel;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (strip_idx_q == LastStrip) begin
          strip_idx_q <= '0;
          seg_idx_q   <= seg_idx_q + 3'd1;
        end else begin
          strip_idx_q <= strip_idx_q + 3'd1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ox_q  <= ox_sel;
      oy_q  <= oy_sel;
      dig_q <= in_digit_i;
    end
    if (cmd_i.emit) begin
      out_q <= cur;
    end
  end

  assign stat_o.slot_free = !out_valid_q || out_ready_i;
  assign stat_o.last      = cur.last_strip;
  assign out_valid_o      = out_valid_q;
  assign out_strip_o      = out_q;
endmodule

### sv/seven_segment_glyph_rasterizer_unit.sv
// Channel  Dir  Payload                                              Role
// in_i     in   command, origin_x, origin_y, digit                   one digit to draw
// cfg_i    in   landscape_mode                                       layout select
// out_o    out  strip_x, strip_y, strip_dir, pixel_mask, bad_digit,  one strip per transaction
//               last_strip
//
// A digit is accepted, then emits one strip per cycle while the output is not stalled:
// 5 strips per lit segment, so 10 to 35 strips (1 for a bad digit), paced by the strip counter.
// One digit is in flight at a time; the next is accepted once the last strip
// sits in the output register. A stalled output holds the strip sequencer.
// Reset clears pen position, layout mode and all handshake state.
module seven_segment_glyph_rasterizer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssgr_in_if.sink    in_i,
  ssgr_cfg_if.sink   cfg_i,
  ssgr_out_if.source out_o
);
  import ssgr_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  state_e    state;
  strip_t    strip;

  ssgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  ssgr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_i.valid),
    .cfg_land_i    (cfg_i.landscape_mode),
    .in_command_i  (in_i.command),
    .in_origin_x_i (in_i.origin_x),
    .in_origin_y_i (in_i.origin_y),
    .in_digit_i    (in_i.digit),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_strip_o   (strip)
  );

  // Config writes are always taken
  assign cfg_i.ready = 1'b1;

  assign out_o.strip_x    = strip.strip_x;
  assign out_o.strip_y    = strip.strip_y;
  assign out_o.strip_dir  = strip.strip_dir;
  assign out_o.pixel_mask = strip.pixel_mask;
  assign out_o.bad_digit  = strip.bad_digit;
  assign out_o.last_strip = strip.last_strip;

  // A digit in progress blocks new input transactions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready && state == StRun)
    else $error("input taken while a digit is in progress");

  // An error result stands alone and carries no pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.bad_digit |-> out_o.last_strip && out_o.pixel_mask == '0)
    else $error("bad digit result malformed");

  // Strips always light pixels and use a defined direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.bad_digit |->
      out_o.pixel_mask != '0 && !(out_o.strip_dir[1] && out_o.strip_dir[0]))
    else $error("strip with no pixels or bad direction");

  // Back to idle only after the final strip was loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state == StRun && $past(state) == StRun && !in_i.ready ##1 in_i.ready |->
      out_o.valid && out_o.last_strip)
    else $error("sequencer left a digit early");
endmodule
